@@ design/sdr_pkg.sv @@
// shared constants and types for the signed 128-bit divider
`timescale 1ns / 1ps
package sdr_pkg;

	localparam int HALF_W = 64;
	localparam int FULL_W = 2 * HALF_W;
	localparam int CNT_W  = $clog2(FULL_W);
	localparam int DATA_W = 4 * HALF_W;

	// status codes carried on the result tuser
	localparam logic STATUS_OK       = 1'b0;
	localparam logic STATUS_DIV_ZERO = 1'b1;

	// control from the sequencer into the divider core
	typedef struct packed {
		logic start;
	} core_ctrl_t;

	// status from the divider core back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PREP = 4'b0010,
		S_DIV  = 4'b0100,
		S_FIX  = 4'b1000
	} state_t;

endpackage

@@ design/signed_128bit_divide_remainder.sv @@
// top level: signed 128-bit divide with remainder, stream in and out
`timescale 1ns / 1ps
// Divides a signed 128-bit dividend by a signed 128-bit divisor and returns the
// quotient truncated toward zero and the remainder with the sign of the
// dividend; the most negative value over minus one wraps. A zero divisor gives
// status 1 on m_tuser, the dividend as quotient and a zero remainder. One item
// is in flight at a time: an item goes from the input transfer through a step
// that takes magnitudes and starts the core, the one-bit-per-cycle restoring
// divider, a step that collects the core result and a sign-fix step that waits
// until the output register is free. Input reopens in the same cycle as the
// result is loaded into the output register. A zero divisor skips the divider
// and goes from the magnitude step straight to sign fix. The result sits in an
// output register until it is taken.
module signed_128bit_divide_remainder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// dividend_high, dividend_low, divisor_high, divisor_low (low bits first)
	input  logic [sdr_pkg::DATA_W-1:0]    s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// quotient_high, quotient_low, remainder_high, remainder_low (low bits first)
	output logic [sdr_pkg::DATA_W-1:0]    m_tdata,
	// status
	output logic                          m_tuser
);

	localparam int HW = sdr_pkg::HALF_W;
	localparam int FW = sdr_pkg::FULL_W;

	sdr_pkg::state_t      state_q;
	logic [FW-1:0]        num_q;
	logic [FW-1:0]        den_q;
	logic                 nneg_q;
	logic                 dneg_q;
	logic                 zero_q;
	logic                 out_valid_q;
	logic [sdr_pkg::DATA_W-1:0] out_data_q;
	logic                 out_user_q;

	sdr_pkg::core_ctrl_t  ctrl;
	sdr_pkg::core_stat_t  stat;
	logic [FW-1:0]        core_quo;
	logic [FW-1:0]        core_rem;
	logic [FW-1:0]        num_mag;
	logic [FW-1:0]        den_mag;
	logic [FW-1:0]        quo_fix;
	logic [FW-1:0]        rem_fix;
	logic                 in_xfer;
	logic                 out_free;
	logic                 den_zero;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == sdr_pkg::S_IDLE);
	assign den_zero = (den_q == '0);

	// operand magnitudes and result sign fixing
	always_comb begin
		num_mag = nneg_q ? (~num_q + 1'b1) : num_q;
		den_mag = dneg_q ? (~den_q + 1'b1) : den_q;
		quo_fix = (nneg_q ^ dneg_q) ? (~num_q + 1'b1) : num_q;
		rem_fix = nneg_q ? (~den_q + 1'b1) : den_q;
	end

	assign ctrl.start = (state_q == sdr_pkg::S_PREP) && !den_zero;

	sdr_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.dividend (num_mag),
		.divisor  (den_mag),
		.stat     (stat),
		.quotient (core_quo),
		.remainder(core_rem)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdr_pkg::S_IDLE;
		end else begin
			case (state_q)
				sdr_pkg::S_IDLE: begin
					if (in_xfer) state_q <= sdr_pkg::S_PREP;
				end
				sdr_pkg::S_PREP: begin
					state_q <= den_zero ? sdr_pkg::S_FIX : sdr_pkg::S_DIV;
				end
				sdr_pkg::S_DIV: begin
					if (stat.done) state_q <= sdr_pkg::S_FIX;
				end
				sdr_pkg::S_FIX: begin
					if (out_free) state_q <= sdr_pkg::S_IDLE;
				end
				default: state_q <= sdr_pkg::S_IDLE;
			endcase
		end
	end

	// operand and result holding registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			num_q  <= {s_tdata[HW-1:0], s_tdata[2*HW-1:HW]};
			den_q  <= {s_tdata[3*HW-1:2*HW], s_tdata[4*HW-1:3*HW]};
			nneg_q <= s_tdata[HW-1];
			dneg_q <= s_tdata[3*HW-1];
		end else if (state_q == sdr_pkg::S_PREP) begin
			zero_q <= den_zero;
			if (den_zero) begin
				nneg_q <= 1'b0;
				dneg_q <= 1'b0;
			end
		end else if ((state_q == sdr_pkg::S_DIV) && stat.done) begin
			num_q <= core_quo;
			den_q <= core_rem;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == sdr_pkg::S_FIX) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == sdr_pkg::S_FIX) && out_free) begin
			out_data_q <= {rem_fix[HW-1:0], rem_fix[FW-1:HW],
				quo_fix[HW-1:0], quo_fix[FW-1:HW]};
			out_user_q <= zero_q ? sdr_pkg::STATUS_DIV_ZERO : sdr_pkg::STATUS_OK;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

`ifndef SYNTHESIS
	// the core is working for the whole divide phase
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sdr_pkg::S_DIV) |-> (stat.busy || stat.done))
		else $error("divider core idle during divide phase");

	// a new result only appears out of the sign-fix phase
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == sdr_pkg::S_FIX))
		else $error("result raised outside sign-fix phase");

	// divide by zero always carries a zero remainder
	a_dz_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == sdr_pkg::STATUS_DIV_ZERO))
		|-> (m_tdata[4*HW-1:2*HW] == '0))
		else $error("divide by zero with nonzero remainder");

	// the core is never started while input is open
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.start |-> !s_tready)
		else $error("core started while accepting input");
`endif

endmodule

@@ design/sdr_core.sv @@
// unsigned radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module sdr_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sdr_pkg::core_ctrl_t           ctrl,
	input  logic [sdr_pkg::FULL_W-1:0]    dividend,
	input  logic [sdr_pkg::FULL_W-1:0]    divisor,
	output sdr_pkg::core_stat_t           stat,
	output logic [sdr_pkg::FULL_W-1:0]    quotient,
	output logic [sdr_pkg::FULL_W-1:0]    remainder
);

	logic [sdr_pkg::FULL_W-1:0] rem_q;
	logic [sdr_pkg::FULL_W-1:0] quo_q;
	logic [sdr_pkg::FULL_W-1:0] div_q;
	logic [sdr_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [sdr_pkg::FULL_W:0]   shifted;
	logic [sdr_pkg::FULL_W:0]   diff;
	logic                       qbit;

	// trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		shifted = {rem_q, quo_q[sdr_pkg::FULL_W-1]};
		diff    = shifted - {1'b0, div_q};
		qbit    = ~diff[sdr_pkg::FULL_W];
	end

	// control: step counter, busy and done flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= sdr_pkg::CNT_W'(sdr_pkg::FULL_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: dividend bits shift out as quotient bits shift in
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[sdr_pkg::FULL_W-1:0] : shifted[sdr_pkg::FULL_W-1:0];
			quo_q <= {quo_q[sdr_pkg::FULL_W-2:0], qbit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
